// ----- design/mdtp_pkg.sv -----
// ----------------------------------------------------------------------------
// mdtp_pkg
// Shared types and constants for the monotonic decimal table parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mdtp_pkg;

  localparam int unsigned LEVELS_DEFAULT = 16;

  localparam logic [7:0] MAX_VALUE = 8'd255;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_FEED    = 2'd0,
    OP_FINISH  = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    MODE_START   = 4'b0001,
    MODE_VALUE   = 4'b0010,
    MODE_AFTER   = 4'b0100,
    MODE_COMMENT = 4'b1000
  } mode_e;

  typedef struct packed {
    logic       status;
    logic       write_valid;
    logic [3:0] write_index;
    logic [7:0] write_value;
    logic [4:0] entries;
  } result_t;

endpackage

`default_nettype wire

// ----- design/mdtp_if.sv -----
// ----------------------------------------------------------------------------
// mdtp_if
// Valid/ready channels for the parser: text items in, table results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdtp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_byte;

  modport source (output valid, output opcode, output char_byte, input ready);
  modport sink   (input valid, input opcode, input char_byte, output ready);
endinterface

interface mdtp_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic       write_valid;
  logic [3:0] write_index;
  logic [7:0] write_value;
  logic [4:0] entries;

  modport source (output valid, output status, output write_valid, output write_index,
                  output write_value, output entries, input ready);
  modport sink   (input valid, input status, input write_valid, input write_index,
                  input write_value, input entries, output ready);
endinterface

`default_nettype wire

// ----- design/monotonic_decimal_table_parser_core.sv -----
// ----------------------------------------------------------------------------
// monotonic_decimal_table_parser_core
// Byte-stream parser that builds a monotonic table of decimal levels.
// ----------------------------------------------------------------------------
//   Channel  Dir  Payload                                          Handshake
//   in_i     in   opcode[1:0], char_byte[7:0]                      valid/ready
//   out_o    out  status, write_valid, write_index[3:0],
//                 write_value[7:0], entries[4:0]                   valid/ready
//
// One item per cycle sustained while the result side is not stalled; the result
// of an item passes through the input register, then the result register,
// before it is shown on out_o.
// The parser state updates as the item moves from the input register to the
// result register, so items take effect strictly in order.
// A stalled result holds in the result register while one more item waits in
// the input register. Reset clears the parser state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module monotonic_decimal_table_parser_core
  import mdtp_pkg::*;
#(
  parameter int unsigned LEVELS = LEVELS_DEFAULT
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mdtp_in_if.sink     in_i,
  mdtp_out_if.source  out_o
);

  logic       in_valid_q;
  logic [1:0] in_opcode_q;
  logic [7:0] in_char_q;
  logic       out_valid_q;
  result_t    out_res_q;
  result_t    step_res;
  logic       advance;

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  mdtp_engine #(
    .LEVELS (LEVELS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .opcode_i    (in_opcode_q),
    .char_byte_i (in_char_q),
    .result_o    (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_opcode_q <= in_i.opcode;
      in_char_q   <= in_i.char_byte;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_res_q.status;
  assign out_o.write_valid = out_res_q.write_valid;
  assign out_o.write_index = out_res_q.write_index;
  assign out_o.write_value = out_res_q.write_value;
  assign out_o.entries     = out_res_q.entries;

endmodule

`default_nettype wire

// ----- design/mdtp_engine.sv -----
// ----------------------------------------------------------------------------
// mdtp_engine
// Parser state and the per-item update: decode, digit accumulate, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module mdtp_engine
  import mdtp_pkg::*;
#(
  parameter int unsigned LEVELS = LEVELS_DEFAULT
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] char_byte_i,
  output result_t         result_o
);

  localparam int unsigned CW = $clog2(LEVELS + 1);
  localparam logic [CW-1:0] LevelsC = CW'(LEVELS);

  mode_e         mode_q, mode_d;
  logic [7:0]    pending_q, pending_d;
  logic [7:0]    prev_q, prev_d;
  logic [CW-1:0] count_q, count_d;
  logic          err_q, err_d;

  logic          wr_valid;
  logic          is_blank, is_remark, is_digit, commit_ok;
  logic [3:0]    digit;
  logic [11:0]   next_val;

  assign is_blank  = (char_byte_i == CHAR_SPACE) || (char_byte_i == CHAR_TAB);
  assign is_remark = (char_byte_i == CHAR_HASH) || (char_byte_i == CHAR_SEMI);
  assign is_digit  = (char_byte_i >= CHAR_ZERO) && (char_byte_i <= CHAR_NINE);
  assign digit     = char_byte_i[3:0];
  assign next_val  = 12'({pending_q, 3'b000}) + 12'({pending_q, 1'b0}) + 12'(digit);
  assign commit_ok = (count_q < LevelsC) && !((count_q != '0) && (pending_q < prev_q));

  always_comb begin
    mode_d    = mode_q;
    pending_d = pending_q;
    prev_d    = prev_q;
    count_d   = count_q;
    err_d     = err_q;
    wr_valid  = 1'b0;
    case (opcode_i)
      OP_RESTART: begin
        mode_d    = MODE_START;
        pending_d = '0;
        prev_d    = '0;
        count_d   = '0;
        err_d     = 1'b0;
      end
      OP_FEED: begin
        if (!err_q && (char_byte_i != CHAR_CR)) begin
          if (char_byte_i == CHAR_LF) begin
            if ((mode_q == MODE_VALUE) || (mode_q == MODE_AFTER)) begin
              if (commit_ok) begin
                wr_valid  = 1'b1;
                prev_d    = pending_q;
                count_d   = count_q + 1'b1;
                mode_d    = MODE_START;
                pending_d = '0;
              end else begin
                err_d = 1'b1;
              end
            end else begin
              mode_d    = MODE_START;
              pending_d = '0;
            end
          end else begin
            case (mode_q)
              MODE_START: begin
                if (is_remark) begin
                  mode_d = MODE_COMMENT;
                end else if (is_digit) begin
                  pending_d = {4'b0000, digit};
                  mode_d    = MODE_VALUE;
                end else if (!is_blank) begin
                  err_d = 1'b1;
                end
              end
              MODE_VALUE, MODE_AFTER: begin
                if (is_digit && (mode_q == MODE_VALUE)) begin
                  if (next_val <= 12'(MAX_VALUE)) begin
                    pending_d = next_val[7:0];
                  end else begin
                    err_d = 1'b1;
                  end
                end else if (is_blank) begin
                  mode_d = MODE_AFTER;
                end else if (is_remark) begin
                  if (commit_ok) begin
                    wr_valid  = 1'b1;
                    prev_d    = pending_q;
                    count_d   = count_q + 1'b1;
                    pending_d = '0;
                    mode_d    = MODE_COMMENT;
                  end else begin
                    err_d = 1'b1;
                  end
                end else begin
                  err_d = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      OP_FINISH: begin
        if (!err_q) begin
          if ((mode_q == MODE_VALUE) || (mode_q == MODE_AFTER)) begin
            if (commit_ok) begin
              wr_valid  = 1'b1;
              prev_d    = pending_q;
              count_d   = count_q + 1'b1;
              pending_d = '0;
              mode_d    = MODE_START;
              err_d     = ((count_q + 1'b1) != LevelsC);
            end else begin
              err_d = 1'b1;
            end
          end else begin
            mode_d = MODE_START;
            err_d  = (count_q != LevelsC);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.status      = err_d;
    result_o.write_valid = wr_valid;
    result_o.write_index = wr_valid ? 4'(count_q) : 4'd0;
    result_o.write_value = wr_valid ? pending_q : 8'd0;
    result_o.entries     = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_START;
      pending_q <= '0;
      prev_q    <= '0;
      count_q   <= '0;
      err_q     <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      pending_q <= pending_d;
      prev_q    <= prev_d;
      count_q   <= count_d;
      err_q     <= err_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/mdtp_checker.sv -----
// ----------------------------------------------------------------------------
// mdtp_port_checker
// Port-level checks on the parser core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mdtp_port_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       status_i,
  input wire logic       write_valid_i,
  input wire logic [3:0] write_index_i,
  input wire logic [7:0] write_value_i,
  input wire logic [4:0] entries_i
);

  logic [1:0] inflight_q;
  logic [4:0] entries_less;
  logic       in_acc, out_acc;

  assign in_acc       = in_valid_i && in_ready_i;
  assign out_acc      = out_valid_i && out_ready_i;
  assign entries_less = entries_i - 5'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 2'd0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 2'd1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(write_valid_i) && $stable(write_index_i)
      && $stable(write_value_i) && $stable(entries_i))
    else $error("Stalled result changed or dropped.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (inflight_q != 2'd0) && (inflight_q != 2'd3))
    else $error("Result shown with no item in flight.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && write_valid_i |-> write_index_i == entries_less[3:0])
    else $error("Write index does not match the entry count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !write_valid_i |-> (write_index_i == 4'd0) && (write_value_i == 8'd0))
    else $error("Write fields not cleared without a write.");

endmodule

bind monotonic_decimal_table_parser_core mdtp_port_checker u_mdtp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .write_valid_i (out_o.write_valid),
  .write_index_i (out_o.write_index),
  .write_value_i (out_o.write_value),
  .entries_i     (out_o.entries)
);

`default_nettype wire
